/* hdl/bgcd_pkg.sv */
// ----------------------------------------------------------------------------
// bgcd_pkg
// Shared types and constants of the binary gcd unit: the default operand
// width and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bgcd_pkg;

	localparam int unsigned BGCD_OPERAND_WIDTH = 32;

	// Datapath operations issued by the controller.
	typedef enum logic [2:0] {
		OP_HOLD  = 3'd0,
		OP_LOAD  = 3'd1,
		OP_TRIV  = 3'd2,
		OP_STRIP = 3'd3,
		OP_STEP  = 3'd4
	} bgcd_op_t;

	typedef struct packed {
		bgcd_op_t op;
		logic     publish;
	} bgcd_cmd_t;

	typedef struct packed {
		logic trivial;
		logic finish;
		logic both_even;
	} bgcd_sts_t;

endpackage

/* hdl/bgcd_datapath.sv */
// ----------------------------------------------------------------------------
// bgcd_datapath
// Operand registers, power-of-two counter, compare and subtract unit and the
// result register of the binary gcd unit.
// ----------------------------------------------------------------------------
module bgcd_datapath import bgcd_pkg::*; #(
	parameter int unsigned OPERAND_WIDTH = BGCD_OPERAND_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bgcd_cmd_t                  cmd,
	output bgcd_sts_t                  sts,
	input  logic [OPERAND_WIDTH-1:0]   first_operand,
	input  logic [OPERAND_WIDTH-1:0]   second_operand,
	output logic [OPERAND_WIDTH-2:0]   divisor
);

	localparam int unsigned SHW = $clog2(OPERAND_WIDTH);

	logic [OPERAND_WIDTH-1:0] x_q, y_q;
	logic [SHW-1:0]           shift_q;
	logic [OPERAND_WIDTH-2:0] divisor_q;

	logic [OPERAND_WIDTH-1:0] mag_a, mag_b, triv_val, result;
	logic                     x_is_one, y_is_one;

	// Two's complement magnitude; the most negative value maps onto itself.
	assign mag_a = first_operand[OPERAND_WIDTH-1]  ? (~first_operand + 1'b1)  : first_operand;
	assign mag_b = second_operand[OPERAND_WIDTH-1] ? (~second_operand + 1'b1) : second_operand;

	assign x_is_one = (x_q == OPERAND_WIDTH'(1));
	assign y_is_one = (y_q == OPERAND_WIDTH'(1));

	always_comb begin
		if (x_q == '0) begin
			triv_val = y_q;
		end else if (y_q == '0) begin
			triv_val = x_q;
		end else if (x_is_one || y_is_one) begin
			triv_val = OPERAND_WIDTH'(1);
		end else begin
			triv_val = x_q;
		end
	end

	assign sts.trivial   = (x_q == '0) || (y_q == '0) || x_is_one || y_is_one || (x_q == y_q);
	assign sts.finish    = (x_q == '0) || (x_q == y_q);
	assign sts.both_even = !x_q[0] && !y_q[0];

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				x_q     <= mag_a;
				y_q     <= mag_b;
				shift_q <= '0;
			end
			OP_TRIV: begin
				y_q <= triv_val;
			end
			OP_STRIP: begin
				if (!x_q[0] && !y_q[0]) begin
					x_q     <= x_q >> 1;
					y_q     <= y_q >> 1;
					shift_q <= shift_q + 1'b1;
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end
			end
			OP_STEP: begin
				if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (x_q < y_q) begin
					x_q <= y_q - x_q;
					y_q <= x_q;
				end else begin
					x_q <= x_q - y_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Restore the common power of two and clamp into the result field.
	assign result = y_q << shift_q;

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			divisor_q <= result[OPERAND_WIDTH-1] ? '1 : result[OPERAND_WIDTH-2:0];
		end
	end

	assign divisor = divisor_q;

	a_strip_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_STRIP) && sts.both_even |=> shift_q == $past(shift_q) + 1'b1)
		else $error("common power of two not counted");

	a_step_y_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_STEP) |-> y_q != '0)
		else $error("subtrahend became zero during reduction");

endmodule

/* hdl/bgcd_ctrl.sv */
// ----------------------------------------------------------------------------
// bgcd_ctrl
// Sequencer of the binary gcd unit: accepts a word, steps the datapath
// through the trivial check, power stripping and reduction, and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module bgcd_ctrl import bgcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  bgcd_sts_t sts,
	output bgcd_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CHECK = 5'b00010,
		ST_STRIP = 5'b00100,
		ST_LOOP  = 5'b01000,
		ST_DONE  = 5'b10000
	} bgcd_state_t;

	bgcd_state_t state_q, state_d;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		cmd.op      = OP_HOLD;
		cmd.publish = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.trivial) begin
					cmd.op  = OP_TRIV;
					state_d = ST_DONE;
				end else begin
					state_d = ST_STRIP;
				end
			end
			ST_STRIP: begin
				cmd.op = OP_STRIP;
				if (!sts.both_even) begin
					state_d = ST_LOOP;
				end
			end
			ST_LOOP: begin
				if (sts.finish) begin
					state_d = ST_DONE;
				end else begin
					cmd.op = OP_STEP;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_CHECK)
		else $error("accepted word did not start the trivial check");

	a_publish_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> out_valid_q && (state_q == ST_IDLE))
		else $error("published result not presented");

endmodule

/* hdl/binary_gcd_unit.sv */
// ----------------------------------------------------------------------------
// binary_gcd_unit
// Greatest common divisor of the magnitudes of two signed operands by
// Stein's binary method, with a controller and a shift-subtract datapath.
// ----------------------------------------------------------------------------
// Usage:
// A word on the input stream carries two signed operands; the sign of each
// is ignored and only its magnitude enters the gcd. Each input word gives
// exactly one output word holding the divisor. When one operand is zero the
// divisor is the other magnitude, so two zeros give zero. A magnitude of one
// gives one and equal magnitudes give that value; these pass from acceptance
// through the check and done states to the output register.
// Other operands run through the stripping of each common factor of two, then
// the halving or compare-and-subtract steps of the reduction loop, each
// done by the datapath's compare and subtract unit. A new word is taken only
// once the previous one has been handed to the output register.
// The output register lets the next word be accepted and worked on while a
// result still waits; if the receiver stalls, the finished result is held
// inside the block until the output register frees up.
// Reset clears the sequencer and the output valid flag; no other state needs
// clearing.
// ----------------------------------------------------------------------------
module binary_gcd_unit import bgcd_pkg::*; #(
	parameter int unsigned OPERAND_WIDTH = BGCD_OPERAND_WIDTH,
	localparam int unsigned IN_TDATA_W  = ((2 * OPERAND_WIDTH + 7) / 8) * 8,
	localparam int unsigned OUT_TDATA_W = ((OPERAND_WIDTH - 1 + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// Fields from bit 0 up: first_operand, second_operand, zero fill.
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// Fields from bit 0 up: divisor, zero fill.
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	bgcd_cmd_t                cmd;
	bgcd_sts_t                sts;
	logic [OPERAND_WIDTH-2:0] divisor;

	bgcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bgcd_datapath #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.first_operand  (s_axis_tdata[OPERAND_WIDTH-1:0]),
		.second_operand (s_axis_tdata[2*OPERAND_WIDTH-1:OPERAND_WIDTH]),
		.divisor        (divisor)
	);

	// The divisor sits in the low bits; the rest of the word is zero.
	assign m_axis_tdata = OUT_TDATA_W'(divisor);

endmodule
